[rtl/core/mbet_pkg.sv]
// Shared types, constants and the mod255 helper for the escape-time pixel block.
// No dependencies; every other file in rtl/core imports this package.
package mbet_pkg;

  // Fixed-point format and field sizes.
  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 10;
  localparam int COORD_BITS = 12;

  // Configuration port.
  localparam int CFG_W  = 32;
  localparam int STEP_W = 31;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_LEFT_REAL      = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOTTOM_IMAG    = 3'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_STEP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_ITERATIONS = 3'd3;
  localparam logic [IDX_W-1:0] REG_COLOR_MODE     = 3'd4;

  localparam logic COLOR_RAMP  = 1'b0;
  localparam logic COLOR_BANDS = 1'b1;

  localparam logic signed [CFG_W-1:0] LEFT_RESET   = -32'sd1073741824;
  localparam logic signed [CFG_W-1:0] BOTTOM_RESET = -32'sd536870912;
  localparam logic [STEP_W-1:0]       STEP_RESET   = 31'd1491308;
  localparam logic [ITER_BITS-1:0]    ITER_RESET   = ITER_BITS'(10);

  // Datapath widths.
  localparam int CNT_W   = ITER_BITS + 1;          // round count, up to max+1
  localparam int SCALE_W = COORD_BITS + STEP_W;    // pixel index times step
  localparam int SUMC_W  = SCALE_W + 2;            // edge plus offset, signed
  localparam int MAG_W   = FRAC_BITS + 2;          // |z| while inside [-2, 2]
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SQ_W    = FRAC_BITS + 3;          // floor of a square, <= 4.0
  localparam int SUM_W   = SQ_W + 1;
  localparam int Z_W     = ((FRAC_BITS + 4 > CFG_W) ? FRAC_BITS + 4 : CFG_W) + 1;

  localparam logic signed [Z_W-1:0] Z_LIMIT     = Z_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [Z_W-1:0] Z_LIMIT_NEG = -Z_LIMIT;
  localparam logic [SUM_W-1:0]      ESC_FOUR    = SUM_W'(1) << (FRAC_BITS + 2);

  // Grey level helpers.
  localparam int GREY_X_W    = ITER_BITS + 2;      // twice the count
  localparam int GREY_CHUNKS = (GREY_X_W + 7) / 8;
  localparam logic [9:0] MOD_ONE = 10'd255;
  localparam logic [9:0] MOD_TWO = 10'd510;
  localparam logic [7:0] GREY_FULL = 8'hFF;
  localparam logic [7:0] GREY_NONE = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_POINT,
    ST_SQUARE,
    ST_UPDATE,
    ST_FINISH
  } mbet_state_t;

  typedef struct packed {
    logic capture;   // latch the pixel position
    logic scale;     // multiply the position by the step
    logic point;     // form c, load z = c, clear the count
    logic square;    // register zr^2, zi^2 and zr*zi
    logic update;    // escape test, count, next z
    logic finish;    // load the result register
  } mbet_cmd_t;

  typedef struct packed {
    logic out_of_range;  // a part of z lies outside [-2, 2]
    logic escaped;       // zr^2 + zi^2 > 4
    logic last_round;    // this round is the final one allowed
  } mbet_status_t;

  // Residue modulo 255: bytes are summed (256 is one modulo 255), then the
  // small sum is folded down by at most two subtractions.
  function automatic logic [7:0] mod255(input logic [GREY_X_W-1:0] x);
    logic [GREY_CHUNKS*8-1:0] padded;
    logic [9:0] acc;
    padded = (GREY_CHUNKS * 8)'(x);
    acc = '0;
    for (int k = 0; k < GREY_CHUNKS; k++) begin
      acc = acc + 10'(padded[k*8 +: 8]);
    end
    if (acc >= MOD_TWO) begin
      acc = acc - MOD_TWO;
    end
    if (acc >= MOD_ONE) begin
      acc = acc - MOD_ONE;
    end
    return acc[7:0];
  endfunction

endpackage

[rtl/core/mbet_ctrl.sv]
// Sequencer for the escape-time pixel block: state machine and result valid.
// Depends on mbet_pkg for the state, command and status types.
module mbet_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  mbet_pkg::mbet_status_t status,
  output mbet_pkg::mbet_cmd_t    cmd
);
  import mbet_pkg::*;

  mbet_state_t state;
  mbet_state_t state_next;
  logic        result_valid_next;
  logic        out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pixel_valid) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:  state_next = ST_POINT;
      ST_POINT:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = status.out_of_range ? ST_FINISH : ST_UPDATE;
      ST_UPDATE: begin
        if (status.escaped || status.last_round) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SQUARE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    pixel_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        pixel_stall = 1'b0;
        cmd.capture = pixel_valid;
      end
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_POINT:  cmd.point  = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_FINISH: cmd.finish = out_free;
      default: cmd = '0;
    endcase
    result_valid_next = cmd.finish || (result_valid && result_stall);
  end

endmodule

[rtl/core/mbet_dp.sv]
// Datapath for the escape-time pixel block: configuration registers, point
// mapping, the z^2 + c round, the round counter and the grey level mapping.
// Depends on mbet_pkg for widths, constants, command/status types and mod255.
module mbet_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mbet_pkg::IDX_W-1:0]          cfg_index,
  input  logic [mbet_pkg::CFG_W-1:0]          cfg_data,
  input  logic [mbet_pkg::COORD_BITS-1:0]     column,
  input  logic [mbet_pkg::COORD_BITS-1:0]     row,
  input  mbet_pkg::mbet_cmd_t                 cmd,
  output mbet_pkg::mbet_status_t              status,
  output logic [mbet_pkg::CNT_W-1:0]          iterations,
  output logic [7:0]                          grey
);
  import mbet_pkg::*;

  localparam logic signed [SUMC_W-1:0] SAT_HI = SUMC_W'($signed({1'b0, {(CFG_W-1){1'b1}}}));
  localparam logic signed [SUMC_W-1:0] SAT_LO = SUMC_W'($signed({1'b1, {(CFG_W-1){1'b0}}}));

  // Configuration.
  logic signed [CFG_W-1:0] left_real;
  logic signed [CFG_W-1:0] bottom_imag;
  logic [STEP_W-1:0]       pixel_step;
  logic [ITER_BITS-1:0]    max_iterations;
  logic                    color_mode;

  // Working registers.
  logic [COORD_BITS-1:0]   col_q;
  logic [COORD_BITS-1:0]   row_q;
  logic [SCALE_W-1:0]      off_r;
  logic [SCALE_W-1:0]      off_i;
  logic signed [CFG_W-1:0] c_r;
  logic signed [CFG_W-1:0] c_i;
  logic signed [Z_W-1:0]   z_r;
  logic signed [Z_W-1:0]   z_i;
  logic [PROD_W-1:0]       sq_r;
  logic [PROD_W-1:0]       sq_i;
  logic [PROD_W-1:0]       cross_p;
  logic                    cross_neg;
  logic [CNT_W-1:0]        count;

  // Combinational values.
  logic signed [SUMC_W-1:0]     sum_r;
  logic signed [SUMC_W-1:0]     sum_i;
  logic signed [CFG_W-1:0]      pt_r;
  logic signed [CFG_W-1:0]      pt_i;
  logic [MAG_W-1:0]             mag_r;
  logic [MAG_W-1:0]             mag_i;
  logic [SQ_W-1:0]              s_r;
  logic [SQ_W-1:0]              s_i;
  logic [PROD_W:0]              cross2;
  logic [PROD_W-FRAC_BITS:0]    cross_q;
  logic                         cross_rem;
  logic signed [Z_W-1:0]        q_ext;
  logic signed [Z_W-1:0]        q_up;
  logic signed [Z_W-1:0]        cross_floor;
  logic signed [Z_W-1:0]        next_r;
  logic signed [Z_W-1:0]        next_i;
  logic [7:0]                   h;
  logic [8:0]                   h2;
  logic [7:0]                   grey_ramp;
  logic [7:0]                   grey_band;
  logic [7:0]                   grey_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_real      <= LEFT_RESET;
      bottom_imag    <= BOTTOM_RESET;
      pixel_step     <= STEP_RESET;
      max_iterations <= ITER_RESET;
      color_mode     <= COLOR_RAMP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEFT_REAL:      left_real      <= $signed(cfg_data);
        REG_BOTTOM_IMAG:    bottom_imag    <= $signed(cfg_data);
        REG_PIXEL_STEP:     pixel_step     <= cfg_data[STEP_W-1:0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[ITER_BITS-1:0];
        REG_COLOR_MODE:     color_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Point mapping: the offset is never negative, but both bounds are clamped.
  always_comb begin
    sum_r = SUMC_W'(left_real) + $signed({2'b00, off_r});
    sum_i = SUMC_W'(bottom_imag) + $signed({2'b00, off_i});
    if (sum_r > SAT_HI) begin
      pt_r = SAT_HI[CFG_W-1:0];
    end else if (sum_r < SAT_LO) begin
      pt_r = SAT_LO[CFG_W-1:0];
    end else begin
      pt_r = sum_r[CFG_W-1:0];
    end
    if (sum_i > SAT_HI) begin
      pt_i = SAT_HI[CFG_W-1:0];
    end else if (sum_i < SAT_LO) begin
      pt_i = SAT_LO[CFG_W-1:0];
    end else begin
      pt_i = sum_i[CFG_W-1:0];
    end
  end

  // Magnitudes are only meaningful while z is inside [-2, 2].
  always_comb begin
    mag_r = z_r[Z_W-1] ? MAG_W'(-z_r) : MAG_W'(z_r);
    mag_i = z_i[Z_W-1] ? MAG_W'(-z_i) : MAG_W'(z_i);
  end

  // Range check on z, then update: floor the squares, test for escape,
  // build the next z.
  always_comb begin
    status.out_of_range = (z_r > Z_LIMIT) || (z_r < Z_LIMIT_NEG) ||
                          (z_i > Z_LIMIT) || (z_i < Z_LIMIT_NEG);
    s_r       = SQ_W'(sq_r[PROD_W-1:FRAC_BITS]);
    s_i       = SQ_W'(sq_i[PROD_W-1:FRAC_BITS]);
    cross2    = {cross_p, 1'b0};
    cross_q   = cross2[PROD_W:FRAC_BITS];
    cross_rem = |cross2[FRAC_BITS-1:0];
    q_ext     = $signed(Z_W'(cross_q));
    q_up      = q_ext + $signed(Z_W'(cross_rem));
    // A negative product rounds toward minus infinity.
    cross_floor = cross_neg ? -q_up : q_ext;
    next_r = $signed(Z_W'(s_r)) - $signed(Z_W'(s_i)) + Z_W'(c_r);
    next_i = cross_floor + Z_W'(c_i);
    status.escaped    = (SUM_W'(s_r) + SUM_W'(s_i)) > ESC_FOUR;
    status.last_round = count == CNT_W'(max_iterations);
  end

  // Grey level from the final count.
  always_comb begin
    h         = mod255({count, 1'b0});
    h2        = {h, 1'b0};
    grey_ramp = (h2 >= 9'(MOD_ONE)) ? 8'(h2 - 9'(MOD_ONE)) : h2[7:0];
    grey_band = h[2] ? GREY_NONE : GREY_FULL;
    grey_val  = (color_mode == COLOR_BANDS) ? grey_band : grey_ramp;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= column;
      row_q <= row;
    end
    if (cmd.scale) begin
      off_r <= SCALE_W'(col_q) * SCALE_W'(pixel_step);
      off_i <= SCALE_W'(row_q) * SCALE_W'(pixel_step);
    end
    if (cmd.point) begin
      c_r   <= pt_r;
      c_i   <= pt_i;
      z_r   <= Z_W'(pt_r);
      z_i   <= Z_W'(pt_i);
      count <= '0;
    end
    if (cmd.square) begin
      sq_r      <= PROD_W'(mag_r) * PROD_W'(mag_r);
      sq_i      <= PROD_W'(mag_i) * PROD_W'(mag_i);
      cross_p   <= PROD_W'(mag_r) * PROD_W'(mag_i);
      cross_neg <= z_r[Z_W-1] ^ z_i[Z_W-1];
    end
    if (cmd.update) begin
      z_r <= next_r;
      z_i <= next_i;
      if (!status.escaped) begin
        count <= count + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      iterations <= count;
      grey       <= grey_val;
    end
  end

endmodule

[rtl/core/mandelbrot_escape_time_pixel.sv]
// Top level of the escape-time pixel block: sequencer plus datapath.
// Depends on mbet_pkg, mbet_ctrl and mbet_dp.
//
//   Channel   Direction  Handshake                  Payload
//   pixel     in         pixel_valid / pixel_stall  column, row
//   result    out        result_valid/result_stall  iterations, grey
//   cfg       in         cfg_write (no handshake)   cfg_index, cfg_data
//
// A pixel is accepted in the idle state and passes the scale and point
// states and then R rounds of z = z^2 + c, where R is the number of rounds
// actually run (at most max_iterations+1). The finish state loads the result
// once the result register is free, and the next pixel can be accepted in
// the cycle after. Each round is the square state, through the three 30x30
// multipliers for zr^2, zi^2 and zr*zi, then the update state for the escape
// test and the add. When z leaves [-2, 2] the last round skips the update.
// Reset is synchronous and restores the default view and settings.
// The result sits in its own register, so a new pixel transaction is taken
// while an earlier result is still stalled; the block only waits when a
// second result is ready before the first one has been taken.
module mandelbrot_escape_time_pixel (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mbet_pkg::IDX_W-1:0]      cfg_index,
  input  logic [mbet_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  logic [mbet_pkg::COORD_BITS-1:0] column,
  input  logic [mbet_pkg::COORD_BITS-1:0] row,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [mbet_pkg::CNT_W-1:0]      iterations,
  output logic [7:0]                      grey
);
  import mbet_pkg::*;

  // Commands flow from the sequencer to the datapath, status flows back.
  mbet_cmd_t    cmd;
  mbet_status_t status;

  mbet_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath holds the configuration registers, the point and z
  // registers, the round counter and the result payload register.
  mbet_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .column     (column),
    .row        (row),
    .cmd        (cmd),
    .status     (status),
    .iterations (iterations),
    .grey       (grey)
  );

endmodule

[rtl/core/mbet_chk.sv]
// Port-level checker for the escape-time pixel block, bound to the top level.
// Depends on mbet_pkg for port widths.
module mbet_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            pixel_valid,
  input logic                            pixel_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input logic [mbet_pkg::CNT_W-1:0]      iterations,
  input logic [7:0]                      grey
);
  import mbet_pkg::*;

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(iterations) && $stable(grey))
    else $error("result payload changed while stalled");

  // One pixel at a time: the block is busy right after taking a pixel.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> pixel_stall)
    else $error("pixel accepted while another one is in flight");

  // A new result only appears out of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_stall))
    else $error("result appeared without a pixel in flight");

  // The count never goes beyond the largest allowed round count.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> iterations <= (CNT_W'(1) << ITER_BITS))
    else $error("iteration count out of range");

endmodule

bind mandelbrot_escape_time_pixel mbet_chk u_mbet_chk (.*);

[sim/tb_top.sv]
// Self-checking testbench for mandelbrot_escape_time_pixel: directed and random pixels.
// Depends on mbet_pkg and the block itself. Expected iteration counts and grey levels
// come from a fixed-point escape-time predictor that runs inside this file.
module tb_top;
  import mbet_pkg::*;

  localparam int  WATCHDOG_LIMIT   = 20000;
  localparam int  LONG_HOLD_CYCLES = 400;
  localparam int  SETTLE_CYCLES    = 4;
  localparam int  END_SETTLE       = 2 * (1 << ITER_BITS) + 8;
  localparam int  MAX_REPORTED     = 40;
  localparam int  RANDOM_PHASES    = 12;
  localparam int  PHASE_PIXELS     = 165;
  localparam int  DEEP_PIXELS      = 40;
  localparam longint Z_BOUND   = longint'(2) << FRAC_BITS;
  localparam longint SUM_BOUND = longint'(4) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  // One expected result; the pixel it belongs to is carried along for messages.
  typedef struct packed {
    pixel_t           origin;
    logic [CNT_W-1:0] iterations;
    logic [7:0]       grey;
  } escape_t;

  // All block inputs start at known values; reset is held from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  logic [COORD_BITS-1:0] column = '0;
  logic [COORD_BITS-1:0] row = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [CNT_W-1:0]      iterations;
  logic [7:0]            grey;

  // Our own copy of the view registers, updated as each write goes out.
  logic signed [CFG_W-1:0] view_left   = LEFT_RESET;
  logic signed [CFG_W-1:0] view_bottom = BOTTOM_RESET;
  logic [STEP_W-1:0]       view_step   = STEP_RESET;
  logic [ITER_BITS-1:0]    view_max    = ITER_RESET;
  logic                    view_mode   = COLOR_RAMP;

  pixel_t  pending_pixels[$];
  escape_t expected_escapes[$];

  int error_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;

  mandelbrot_escape_time_pixel u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .column       (column),
    .row          (row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .iterations   (iterations),
    .grey         (grey)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Saturate an exact coordinate sum to the signed 32-bit range.
  function automatic longint clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      return longint'(32'sh7FFF_FFFF);
    end
    if (v < -longint'(64'sh8000_0000)) begin
      return -longint'(64'sh8000_0000);
    end
    return v;
  endfunction

  // Escape-time predictor. Every fixed-point product is floored with an
  // arithmetic shift, and z only gets squared while both parts are within
  // [-2, 2], so everything fits comfortably in 64 bits.
  function automatic escape_t compute_escape(input pixel_t px);
    longint      cr, ci, zr, zi, sq_r, sq_i, cross_p;
    logic        flip, escaped;
    int unsigned count, round, h;
    escape_t     res;
    cr = clamp32(longint'(view_left) + longint'(px.column) * longint'(view_step));
    ci = clamp32(longint'(view_bottom) + longint'(px.row) * longint'(view_step));
    zr = 0;
    zi = 0;
    sq_r = 0;
    sq_i = 0;
    count = 0;
    round = 0;
    escaped = 1'b0;
    while (!escaped && round <= view_max) begin
      cross_p = (zr < 0 ? -zr : zr) * (zi < 0 ? -zi : zi) * 2;
      flip = (zr < 0) != (zi < 0);
      zr = sq_r - sq_i + cr;
      zi = ((flip ? -cross_p : cross_p) >>> FRAC_BITS) + ci;
      if (zr > Z_BOUND || zr < -Z_BOUND || zi > Z_BOUND || zi < -Z_BOUND) begin
        escaped = 1'b1;
      end else begin
        // The squares are kept for the next update when the point stays inside.
        sq_r = (zr * zr) >>> FRAC_BITS;
        sq_i = (zi * zi) >>> FRAC_BITS;
        if (sq_r + sq_i > SUM_BOUND) begin
          escaped = 1'b1;
        end else begin
          count++;
        end
      end
      round++;
    end
    h = (2 * count) % 255;
    res.origin = px;
    res.iterations = count[CNT_W-1:0];
    if (view_mode == COLOR_RAMP) begin
      res.grey = 8'((2 * h) % 255);
    end else begin
      res.grey = (h % 8 < 4) ? GREY_FULL : GREY_NONE;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTED) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    error_count++;
  endtask

  // One register write; bits above a register's width and unknown indexes
  // leave our copy untouched, as they should leave the block untouched.
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LEFT_REAL:      view_left   = data;
      REG_BOTTOM_IMAG:    view_bottom = data;
      REG_PIXEL_STEP:     view_step   = data[STEP_W-1:0];
      REG_MAX_ITERATIONS: view_max    = data[ITER_BITS-1:0];
      REG_COLOR_MODE:     view_mode   = data[0];
      default: ;
    endcase
  endtask

  // Writes all five registers, junk above the step, limit and mode fields,
  // then hits unused indexes with random data, which must change nothing.
  task automatic apply_view(input logic signed [CFG_W-1:0] left,
                            input logic signed [CFG_W-1:0] bottom,
                            input logic [STEP_W-1:0] step,
                            input logic [ITER_BITS-1:0] max_iter,
                            input logic mode);
    logic [CFG_W-1:0] junk;
    logic [IDX_W-1:0] spare_idx;
    junk = $urandom();
    write_register(REG_LEFT_REAL, left);
    write_register(REG_BOTTOM_IMAG, bottom);
    write_register(REG_PIXEL_STEP, {junk[CFG_W-1:STEP_W], step});
    write_register(REG_MAX_ITERATIONS, {junk[CFG_W-1:ITER_BITS], max_iter});
    write_register(REG_COLOR_MODE, {junk[CFG_W-1:1], mode});
    for (int k = REG_COLOR_MODE + 1; k < (1 << IDX_W); k++) begin
      spare_idx = k[IDX_W-1:0];
      write_register(spare_idx, $urandom());
    end
  endtask

  task automatic queue_pixel(input int col, input int rw);
    pixel_t px;
    px.column = col[COORD_BITS-1:0];
    px.row    = rw[COORD_BITS-1:0];
    pending_pixels.push_back(px);
  endtask

  // Blocks until every queued pixel has been taken and every result checked.
  // Each pixel yields exactly one result, so the block is idle afterwards.
  task automatic drain();
    while (pending_pixels.size() != 0 || expected_escapes.size() != 0 || pixel_valid) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver. A stalled transaction is held as it is; otherwise the next
  // pending pixel is offered unless the sender decides to idle this cycle.
  // The expected result is worked out the moment a transaction is accepted.
  always @(posedge clk) begin : pixel_driver
    logic taken;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      taken = pixel_valid && !pixel_stall;
      if (taken) begin
        expected_escapes.push_back(compute_escape(pending_pixels[0]));
        pending_pixels.delete(0);
      end
      if (pixel_valid && !taken) begin
        // Hold valid and payload until the block takes them.
      end else if (pending_pixels.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        pixel_valid <= 1'b1;
        column      <= pending_pixels[0].column;
        row         <= pending_pixels[0].row;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Result monitor and stall generator. A long hold-off is started whenever
  // the stimulus asks for one and is counted down here, cycle by cycle.
  always @(posedge clk) begin : result_monitor
    escape_t want;
    int      hold_left;
    int      hold_served;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
      hold_served = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_escapes.size() == 0) begin
          report_mismatch($sformatf("unexpected result iterations %0d grey %0d",
                                    iterations, grey));
        end else begin
          want = expected_escapes.pop_front();
          if (iterations !== want.iterations) begin
            report_mismatch($sformatf("pixel (%0d,%0d) iterations %0d, expected %0d",
                                      want.origin.column, want.origin.row,
                                      iterations, want.iterations));
          end
          if (grey !== want.grey) begin
            report_mismatch($sformatf("pixel (%0d,%0d) grey %0d, expected %0d",
                                      want.origin.column, want.origin.row,
                                      grey, want.grey));
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int pixels;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset view (about -4..18.75 by -2..20.75,
    // round limit of ten): the frame corners, the middle pixel, the origin,
    // a point just past -2 on the real axis, and two points inside the set.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(2048, 2048);
    queue_pixel(720, 360);
    queue_pixel(360, 360);
    queue_pixel(630, 360);
    queue_pixel(675, 450);
    drain();

    // Most negative left edge, most positive bottom edge, largest step and
    // the largest round limit: coordinates saturate at the top end.
    apply_view(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 10'd1023, COLOR_BANDS);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(0, 1);
    queue_pixel(4095, 4095);
    drain();

    // Zero step: every pixel lands on c = 0 and runs the full 1024 rounds.
    apply_view(32'sd0, 32'sd0, 31'd0, 10'd1023, COLOR_RAMP);
    queue_pixel(4095, 4095);
    queue_pixel(1234, 2345);
    drain();

    // Most positive left edge, most negative bottom edge, smallest nonzero step,
    // and a zero round limit, which still runs one round.
    apply_view(32'sh7FFF_FFFF, 32'sh8000_0000, 31'd1, 10'd0, COLOR_BANDS);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();

    // One round at c = -1, which stays inside, so the count is one.
    apply_view(-32'sd268435456, 32'sd0, 31'd1, 10'd0, COLOR_BANDS);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    drain();

    // Random phases. Most views frame the set (real -2.5..3.5, imaginary
    // -1.25..3.25) so that counts spread out; two use arbitrary register
    // values, and the last allows 1024 rounds with fewer pixels.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 65;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 65;
        end
        default: begin
          sender_idle_pct = 33;
          receiver_stall_pct = 33;
        end
      endcase
      pixels = PHASE_PIXELS;
      if (p == 4 || p == 9) begin
        apply_view($urandom(), $urandom(), STEP_W'($urandom()),
                   ITER_BITS'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end else if (p == RANDOM_PHASES - 1) begin
        apply_view(-671088640 + int'($urandom_range(0, 805306368)),
                   -335544320 + int'($urandom_range(0, 402653184)),
                   STEP_W'($urandom_range(16384, 196608)), 10'd1023,
                   1'($urandom_range(0, 1)));
        pixels = DEEP_PIXELS;
      end else begin
        apply_view(-671088640 + int'($urandom_range(0, 805306368)),
                   -335544320 + int'($urandom_range(0, 402653184)),
                   STEP_W'($urandom_range(16384, 196608)),
                   ITER_BITS'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end
      // In the first phase the receiver holds off for a long stretch while
      // pixels keep coming, so the block fills up and stalls its input.
      if (p == 0) begin
        hold_requests++;
      end
      for (int i = 0; i < pixels; i++) begin
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        // Halfway through one phase the sender pauses until all results are in.
        if (p == 2 && i == pixels / 2) begin
          drain();
        end
      end
      drain();
    end

    // Anything that shows up during this quiet stretch is flagged as extra.
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mbet_pkg.sv
rtl/core/mbet_ctrl.sv
rtl/core/mbet_dp.sv
rtl/core/mandelbrot_escape_time_pixel.sv
rtl/core/mbet_chk.sv
sim/tb_top.sv
